[hw/rtl/mdas_pkg.sv]
`default_nettype none

package mdas_pkg;

	// Fixed field widths of the request and response items.
	localparam int INDEX_FIELDS = 4;
	localparam int INDEX_W      = 12;
	localparam int BOUND_W      = 13;
	localparam int DIMS_W       = 3;
	localparam int VALUE_W      = 32;
	// Widest element offset carried between front and back (deepest store is 2**20).
	localparam int OFS_W        = 20;
	localparam int PADDR_W      = 5;
	localparam int PDATA_W      = 32;

	localparam logic OP_READ      = 1'b0;
	localparam logic OP_WRITE     = 1'b1;
	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_RANGE = 1'b1;

	// Register indexes on the configuration port (byte address is four times this).
	localparam logic [2:0] REG_NUM_DIMS = 3'd0;
	localparam logic [2:0] REG_BOUND_0  = 3'd1;
	localparam logic [2:0] REG_BOUND_1  = 3'd2;
	localparam logic [2:0] REG_BOUND_2  = 3'd3;
	localparam logic [2:0] REG_BOUND_3  = 3'd4;

	typedef logic [INDEX_FIELDS-1:0][BOUND_W-1:0] bound_arr_t;
	typedef logic [INDEX_FIELDS-1:0][INDEX_W-1:0] index_arr_t;

	// One classified access, as queued between the front and the back.
	typedef struct packed {
		logic                      opcode;
		logic                      bad;
		logic [OFS_W-1:0]          offset;
		logic signed [VALUE_W-1:0] wdata;
	} op_t;

endpackage

`default_nettype wire

[hw/rtl/mdas_if.sv]
`default_nettype none

interface mdas_req_if import mdas_pkg::*;;
	logic                      valid;
	logic                      ready;
	logic                      opcode;
	logic [INDEX_W-1:0]        index_0;
	logic [INDEX_W-1:0]        index_1;
	logic [INDEX_W-1:0]        index_2;
	logic [INDEX_W-1:0]        index_3;
	logic signed [VALUE_W-1:0] write_value;

	modport source (output valid, opcode, index_0, index_1, index_2, index_3, write_value,
		input ready);
	modport sink (input valid, opcode, index_0, index_1, index_2, index_3, write_value,
		output ready);
endinterface

interface mdas_rsp_if import mdas_pkg::*;;
	logic                      valid;
	logic                      ready;
	logic                      status;
	logic signed [VALUE_W-1:0] read_value;

	modport source (output valid, status, read_value, input ready);
	modport sink (input valid, status, read_value, output ready);
endinterface

`default_nettype wire

[hw/rtl/mdas_ram.sv]
`default_nettype none

module mdas_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/mdas_front.sv]
`default_nettype none

module mdas_front import mdas_pkg::*; #(
	parameter int MEM_DEPTH = 4096
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [DIMS_W-1:0] n_dims,
	input  wire bound_arr_t        bounds,
	mdas_req_if.sink               req,
	input  wire logic              q_full,
	output logic                   push,
	output op_t                    push_op
);

	localparam int AW = $clog2(MEM_DEPTH);
	localparam int PW = AW + BOUND_W;
	localparam int SW = AW + BOUND_W + 1;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_CALC = 1'b1;

	logic                      state_q;
	logic [DIMS_W-1:0]         dim_q;
	logic [AW-1:0]             acc_q;
	logic                      over_q;
	logic                      bad_q;
	logic                      opcode_q;
	index_arr_t                idx_q;
	logic signed [VALUE_W-1:0] wval_q;

	index_arr_t    idx_in;
	logic          accept;
	logic          done;
	logic          idx_bad;
	logic [SW-1:0] first_ext;
	logic [PW-1:0] prod;
	logic [SW-1:0] sum;

	assign idx_in = {req.index_3, req.index_2, req.index_1, req.index_0};

	assign done      = (state_q == ST_CALC) && (dim_q == n_dims);
	assign push      = done && !q_full;
	assign req.ready = (state_q == ST_IDLE) || push;
	assign accept    = req.valid && req.ready;

	always_comb begin
		idx_bad = 1'b0;
		for (int d = 0; d < INDEX_FIELDS; d++) begin
			if ((DIMS_W'(d) < n_dims) && ({1'b0, idx_in[d]} >= bounds[d])) begin
				idx_bad = 1'b1;
			end
		end
	end

	// One Horner step per cycle: acc = acc * bound + index.
	assign first_ext = SW'(req.index_0);
	assign prod      = PW'(acc_q) * PW'(bounds[dim_q[1:0]]);
	assign sum       = SW'(prod) + SW'(idx_q[dim_q[1:0]]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			dim_q   <= '0;
		end else if (accept) begin
			state_q <= ST_CALC;
			dim_q   <= DIMS_W'(1);
		end else if (push) begin
			state_q <= ST_IDLE;
		end else if (state_q == ST_CALC && !done) begin
			dim_q <= dim_q + DIMS_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			opcode_q <= req.opcode;
			idx_q    <= idx_in;
			wval_q   <= req.write_value;
			bad_q    <= idx_bad;
			acc_q    <= first_ext[AW-1:0];
			over_q   <= first_ext >= SW'(MEM_DEPTH);
		end else if (state_q == ST_CALC && !done) begin
			acc_q  <= sum[AW-1:0];
			over_q <= over_q || (sum >= SW'(MEM_DEPTH));
		end
	end

	always_comb begin
		push_op.opcode = opcode_q;
		push_op.bad    = bad_q || over_q;
		push_op.offset = OFS_W'(acc_q);
		push_op.wdata  = wval_q;
	end

	a_calc_dim_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CALC) |-> (dim_q <= n_dims))
		else $error("dimension step ran past the dimensions in use");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_CALC) && (dim_q == DIMS_W'(1)))
		else $error("accepted request did not start the offset walk");

endmodule

`default_nettype wire

[hw/rtl/mdas_queue.sv]
`default_nettype none

module mdas_queue import mdas_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire op_t  push_op,
	input  wire logic pop,
	output op_t       pop_op,
	output logic      full,
	output logic      empty
);

	op_t        slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full   = (cnt_q == 2'd2);
	assign empty  = (cnt_q == 2'd0);
	assign pop_op = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_op;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into a full queue");

endmodule

`default_nettype wire

[hw/rtl/mdas_back.sv]
`default_nettype none

module mdas_back import mdas_pkg::*; #(
	parameter int MEM_DEPTH  = 4096,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic q_empty,
	input  wire op_t  pop_op,
	output logic      pop,
	mdas_rsp_if.source rsp
);

	localparam int AW = $clog2(MEM_DEPTH);

	logic                      s1_valid_q;
	logic                      s1_read_s1;
	logic                      s1_bad_s1;
	logic                      out_valid_q;
	logic                      out_status_q;
	logic signed [VALUE_W-1:0] out_value_q;

	logic                  s1_adv;
	logic                  ram_en;
	logic [DATA_WIDTH-1:0] ram_rdata;
	logic [63:0]           wd64;
	logic [63:0]           rd64;

	assign s1_adv = s1_valid_q && (!out_valid_q || rsp.ready);
	assign pop    = !q_empty && (!s1_valid_q || s1_adv);
	assign ram_en = pop && !pop_op.bad;

	assign wd64 = 64'($signed(pop_op.wdata));
	assign rd64 = 64'($signed(ram_rdata));

	mdas_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (MEM_DEPTH)
	) u_ram (
		.clk   (clk),
		.en    (ram_en),
		.we    (pop_op.opcode == OP_WRITE),
		.addr  (pop_op.offset[AW-1:0]),
		.wdata (wd64[DATA_WIDTH-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			s1_read_s1 <= (pop_op.opcode == OP_READ) && !pop_op.bad;
			s1_bad_s1  <= pop_op.bad;
		end
		if (s1_adv) begin
			out_status_q <= s1_bad_s1 ? STATUS_RANGE : STATUS_OK;
			out_value_q  <= s1_read_s1 ? rd64[VALUE_W-1:0] : '0;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = out_status_q;
	assign rsp.read_value = out_value_q;

	a_pop_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> s1_valid_q)
		else $error("popped access did not reach the memory stage");

	a_stall_holds_rdata: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !s1_adv && s1_read_s1) |=> (s1_valid_q && $stable(ram_rdata)))
		else $error("memory read data changed while its access was stalled");

endmodule

`default_nettype wire

[hw/rtl/multidim_array_address_store.sv]
`default_nettype none

// Row-major multidimensional array store. A flat memory of MEM_DEPTH elements of
// DATA_WIDTH bits is presented as an array of num_dims dimensions (1 to 4, a
// value of 0 acting as 1 and larger values clamped) with extents bound_0 (the
// outermost) to bound_3, written through the APB port at byte addresses 0, 4,
// 8, 12 and 16. Each request transfer carries a read or a write and one index
// per dimension; indices of unused dimensions are ignored. An index at or
// above its bound, or a flat offset at or above MEM_DEPTH, returns status 1
// with a zero read_value and leaves memory untouched. Every request gives
// exactly one response transfer, in order; writes and errors return a zero
// read_value. The front end folds the indices into an offset with one
// multiply-add per dimension after the first on a single shared multiplier,
// so a request occupies it while the dimensions in use are walked, and it
// takes the next request as it hands the current one on. A two-entry queue
// then hands the access to the back end, which issues one memory access per
// cycle while its response is not stalled and registers the response, so a
// request passes the offset walk, the queue, the memory stage and the
// response register. The memory is not cleared after reset: reading an element
// that was never written returns undefined data.
// Configuration should only be changed while no request is outstanding.
module multidim_array_address_store import mdas_pkg::*; #(
	parameter int MAX_DIMS   = 4,
	parameter int MEM_DEPTH  = 4096,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	mdas_req_if.sink                req,
	mdas_rsp_if.source              rsp
);

	// Dimensions that can actually be used: the smaller of MAX_DIMS and the
	// number of index fields in a request.
	localparam int DIM_LIMIT = (MAX_DIMS < INDEX_FIELDS) ? MAX_DIMS : INDEX_FIELDS;

	logic [DIMS_W-1:0] num_dims_q;
	bound_arr_t        bound_q;

	logic [DIMS_W-1:0] n_dims;
	logic [2:0]        reg_sel;
	logic              cfg_wr;

	logic q_push;
	logic q_pop;
	logic q_full;
	logic q_empty;
	op_t  q_push_op;
	op_t  q_pop_op;

	// The configuration port answers every transfer at once.
	assign pready  = 1'b1;
	assign reg_sel = paddr[PADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_dims_q <= DIMS_W'(1);
			for (int d = 0; d < INDEX_FIELDS; d++) begin
				bound_q[d] <= BOUND_W'(1);
			end
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_NUM_DIMS: num_dims_q <= pwdata[DIMS_W-1:0];
				REG_BOUND_0:  bound_q[0] <= pwdata[BOUND_W-1:0];
				REG_BOUND_1:  bound_q[1] <= pwdata[BOUND_W-1:0];
				REG_BOUND_2:  bound_q[2] <= pwdata[BOUND_W-1:0];
				REG_BOUND_3:  bound_q[3] <= pwdata[BOUND_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_NUM_DIMS: prdata = PDATA_W'(num_dims_q);
			REG_BOUND_0:  prdata = PDATA_W'(bound_q[0]);
			REG_BOUND_1:  prdata = PDATA_W'(bound_q[1]);
			REG_BOUND_2:  prdata = PDATA_W'(bound_q[2]);
			REG_BOUND_3:  prdata = PDATA_W'(bound_q[3]);
			default:      prdata = '0;
		endcase
	end

	// Effective dimension count: zero behaves as one, and anything above the
	// limit is clamped to it.
	always_comb begin
		if (num_dims_q == '0) begin
			n_dims = DIMS_W'(1);
		end else if (num_dims_q > DIMS_W'(DIM_LIMIT)) begin
			n_dims = DIMS_W'(DIM_LIMIT);
		end else begin
			n_dims = num_dims_q;
		end
	end

	// The front end takes a request transfer, checks each index in use against its
	// bound in parallel, and then walks the dimensions to form the offset.
	mdas_front #(
		.MEM_DEPTH (MEM_DEPTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.n_dims  (n_dims),
		.bounds  (bound_q),
		.req     (req),
		.q_full  (q_full),
		.push    (q_push),
		.push_op (q_push_op)
	);

	// The queue lets the front end start on the next request while the back
	// end is held up by a stalled response.
	mdas_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_op (q_push_op),
		.pop     (q_pop),
		.pop_op  (q_pop_op),
		.full    (q_full),
		.empty   (q_empty)
	);

	// The back end owns the element memory and the response register.
	mdas_back #(
		.MEM_DEPTH  (MEM_DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.pop_op  (q_pop_op),
		.pop     (q_pop),
		.rsp     (rsp)
	);

endmodule

`default_nettype wire
